// ===== rtl/core/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

	localparam int CODE_W          = 32;
	localparam int LEN_W           = 6;
	localparam int SYM_W           = 8;
	localparam int BYTE_W          = 8;
	localparam int PEND_W          = 7;
	localparam int PCNT_W          = 3;
	localparam int MAX_RESULTS     = 4;
	localparam int NRES_W          = 3;
	localparam int ACC_W           = PEND_W + CODE_W;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_ENCODE = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
		logic              is_tail;
	} out_item_t;

	// Bytes produced by one item, first byte in the top lane.
	typedef struct packed {
		logic [MAX_RESULTS*BYTE_W-1:0] bytes;
		logic [NRES_W-1:0]             count;
		logic                          tail;
	} pack_res_t;

endpackage

// ===== rtl/core/huffman_code_bit_packer.sv =====
// Top level of the Huffman code bit packer.
//
//  channel | signals                        | item
//  src     | src_valid, src_stall, src_data | load / encode / flush command
//  res     | res_valid, res_stall, res_data | one packed byte
//
// An item is taken in the table-read cycle and packed when the result
// buffer is free; an encode gives 0 to 4 bytes, one per cycle from the
// buffer unless res stalls, and the next item may pack as the last leaves.
// Loads give no byte and never enter the packing stage. Reset clears the
// pending bits and control; the code table is not cleared. Stalls on res
// hold the buffer and back up into src once the item behind it is waiting.
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  hcbp_pkg::in_item_t   src_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output hcbp_pkg::out_item_t  res_data
);

	localparam int CodeW = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;

	logic                        s1_valid_q;
	logic [1:0]                  s1_cmd_q;
	logic                        accept;
	logic                        adv;
	logic                        buf_free;
	logic [CodeW-1:0]            rd_code;
	logic [hcbp_pkg::LEN_W-1:0]  rd_len;
	hcbp_pkg::pack_res_t         pack_res;

	assign adv       = s1_valid_q && buf_free;
	assign src_stall = s1_valid_q && !buf_free;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= (src_data.cmd == hcbp_pkg::CMD_ENCODE)
				|| (src_data.cmd == hcbp_pkg::CMD_FLUSH);
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_cmd_q <= src_data.cmd;
		end
	end

	hcbp_table #(
		.CodeW(CodeW)
	) u_table (
		.clk     (clk),
		.wr_en   (accept && src_data.cmd == hcbp_pkg::CMD_LOAD),
		.wr_addr (src_data.symbol),
		.wr_code (src_data.code_bits),
		.wr_len  (src_data.code_len),
		.rd_en   (accept && src_data.cmd == hcbp_pkg::CMD_ENCODE),
		.rd_addr (src_data.symbol),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	hcbp_pack #(
		.CodeW(CodeW)
	) u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (s1_cmd_q),
		.code   (rd_code),
		.len    (rd_len),
		.res    (pack_res)
	);

	hcbp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (pack_res),
		.free      (buf_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	a_tail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.is_tail |-> res_data.last_of_run)
		else $error("tail byte not marked last");

	a_empty_buf_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !res_valid |-> !src_stall)
		else $error("input stalled with an empty result buffer");

	a_flush_one_tail: assert property (@(posedge clk) disable iff (!arst_n)
		adv && s1_cmd_q == hcbp_pkg::CMD_FLUSH |=>
			!res_valid || (res_data.is_tail && res_data.last_of_run))
		else $error("flush left more than the tail byte");

	a_encode_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_data.cmd == hcbp_pkg::CMD_ENCODE |=> s1_valid_q)
		else $error("accepted encode item lost");

endmodule

// ===== rtl/core/hcbp_table.sv =====
// Code table: 256 entries of code pattern and length, registered read.
module hcbp_table #(
	parameter int CodeW = 32
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [hcbp_pkg::SYM_W-1:0]     wr_addr,
	input  logic [hcbp_pkg::CODE_W-1:0]    wr_code,
	input  logic [hcbp_pkg::LEN_W-1:0]     wr_len,
	input  logic                           rd_en,
	input  logic [hcbp_pkg::SYM_W-1:0]     rd_addr,
	output logic [CodeW-1:0]               rd_code,
	output logic [hcbp_pkg::LEN_W-1:0]     rd_len
);

	localparam int Depth = 1 << hcbp_pkg::SYM_W;

	logic [CodeW-1:0]            code_mem [Depth];
	logic [hcbp_pkg::LEN_W-1:0]  len_mem  [Depth];

	logic [hcbp_pkg::LEN_W-1:0]  len_sat;
	logic [hcbp_pkg::CODE_W-1:0] code_masked;

	// overlong codes saturate; only the low len bits of the pattern are kept
	always_comb begin
		if (wr_len > hcbp_pkg::LEN_W'(CodeW)) begin
			len_sat = hcbp_pkg::LEN_W'(CodeW);
		end else begin
			len_sat = wr_len;
		end
		code_masked = wr_code & ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[wr_addr] <= code_masked[CodeW-1:0];
			len_mem[wr_addr]  <= len_sat;
		end
		if (rd_en) begin
			rd_code <= code_mem[rd_addr];
			rd_len  <= len_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/hcbp_pack.sv =====
// Bit accumulator: joins pending bits with a code and splits whole bytes.
module hcbp_pack #(
	parameter int CodeW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [1:0]                  cmd,
	input  logic [CodeW-1:0]            code,
	input  logic [hcbp_pkg::LEN_W-1:0]  len,
	output hcbp_pkg::pack_res_t         res
);

	logic [hcbp_pkg::PEND_W-1:0] pend_bits_q;
	logic [hcbp_pkg::PCNT_W-1:0] pend_cnt_q;
	logic [hcbp_pkg::PEND_W-1:0] pend_bits_d;
	logic [hcbp_pkg::PCNT_W-1:0] pend_cnt_d;

	logic [hcbp_pkg::ACC_W-1:0]  acc;
	logic [hcbp_pkg::LEN_W-1:0]  total;
	logic [hcbp_pkg::ACC_W:0]    left_just;
	logic [hcbp_pkg::BYTE_W-1:0] tail_byte;

	always_comb begin
		acc = (hcbp_pkg::ACC_W'(pend_bits_q) << len)
			| hcbp_pkg::ACC_W'(code);
		total = hcbp_pkg::LEN_W'(pend_cnt_q) + len;
		// first bit of the run lands in the top bit of the word
		left_just = {1'b0, acc} << (hcbp_pkg::LEN_W'(hcbp_pkg::ACC_W + 1) - total);
		tail_byte = hcbp_pkg::BYTE_W'({1'b0, pend_bits_q}
			<< (4'd8 - {1'b0, pend_cnt_q}));

		res         = '0;
		pend_bits_d = pend_bits_q;
		pend_cnt_d  = pend_cnt_q;
		unique case (cmd)
			hcbp_pkg::CMD_ENCODE: begin
				res.bytes   = left_just[hcbp_pkg::ACC_W -: hcbp_pkg::MAX_RESULTS*hcbp_pkg::BYTE_W];
				res.count   = total[hcbp_pkg::LEN_W-1:3];
				pend_cnt_d  = total[2:0];
				pend_bits_d = acc[hcbp_pkg::PEND_W-1:0]
					& ~({hcbp_pkg::PEND_W{1'b1}} << total[2:0]);
			end
			hcbp_pkg::CMD_FLUSH: begin
				res.bytes[hcbp_pkg::MAX_RESULTS*hcbp_pkg::BYTE_W-1 -: hcbp_pkg::BYTE_W] =
					tail_byte;
				res.count   = (pend_cnt_q != '0) ? hcbp_pkg::NRES_W'(1) : '0;
				res.tail    = 1'b1;
				pend_cnt_d  = '0;
				pend_bits_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (adv) begin
			pend_bits_q <= pend_bits_d;
			pend_cnt_q  <= pend_cnt_d;
		end
	end

endmodule

// ===== rtl/core/hcbp_outbuf.sv =====
// Result buffer: holds up to four bytes of one item and sends one a cycle unless res stalls.
module hcbp_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  hcbp_pkg::pack_res_t  res,
	output logic                 free,
	output logic                 res_valid,
	input  logic                 res_stall,
	output hcbp_pkg::out_item_t  res_data
);

	logic [hcbp_pkg::MAX_RESULTS*hcbp_pkg::BYTE_W-1:0] bytes_q;
	logic [hcbp_pkg::NRES_W-1:0]                       cnt_q;
	logic                                              tail_q;
	logic                                              take;

	assign res_valid = (cnt_q != '0);
	assign take      = res_valid && !res_stall;
	// empty, or the last byte leaves this cycle
	assign free      = (cnt_q == '0) || (cnt_q == hcbp_pkg::NRES_W'(1) && !res_stall);

	always_comb begin
		res_data.out_byte    = bytes_q[hcbp_pkg::MAX_RESULTS*hcbp_pkg::BYTE_W-1 -: hcbp_pkg::BYTE_W];
		res_data.last_of_run = (cnt_q == hcbp_pkg::NRES_W'(1));
		res_data.is_tail     = tail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (take) begin
			cnt_q <= cnt_q - hcbp_pkg::NRES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			tail_q  <= res.tail;
		end else if (take) begin
			bytes_q <= bytes_q << hcbp_pkg::BYTE_W;
		end
	end

endmodule

// ===== tb/huffman_code_bit_packer_tb.sv =====
// Self-checking testbench for the Huffman code bit packer: table loads, encodes and flushes.
module huffman_code_bit_packer_tb;
	import hcbp_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LEN_CAP = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
	localparam int RANDOM_ITEMS = 175;
	localparam int QUIET_TAIL = 30;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	in_item_t src_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_item_t res_data;

	huffman_code_bit_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	in_item_t cmd_queue[$];
	out_item_t expected_bytes[$];

	// predictor state
	logic [CODE_W-1:0] code_table[256];
	logic [LEN_W-1:0] len_table[256];
	logic [PEND_W-1:0] held_bits = '0;
	logic [PCNT_W-1:0] held_count = '0;

	int unsigned cycle_count = 0;
	int mismatches = 0;
	int n_loads = 0;
	int n_encodes = 0;
	int n_flushes = 0;
	int n_bytes = 0;
	int n_tails = 0;
	int src_gap = 0;
	int stall_left = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Idle bursts are off for one window in four and for the last items of the run.
	function automatic bit bursts_allowed();
		return cmd_queue.size() > QUIET_TAIL && cycle_count[8:7] != 2'd0;
	endfunction

	function automatic void pack_item(in_item_t it);
		logic [ACC_W-1:0] acc;
		logic [LEN_W-1:0] len;
		int total;
		out_item_t run[$];
		out_item_t ob;
		case (it.cmd)
		CMD_LOAD: begin
			len = (it.code_len > LEN_CAP) ? LEN_W'(LEN_CAP) : it.code_len;
			len_table[it.symbol] = len;
			code_table[it.symbol] = CODE_W'({32'b0, it.code_bits} & ((64'd1 << len) - 64'd1));
		end
		CMD_ENCODE: begin
			len = len_table[it.symbol];
			acc = (ACC_W'(held_bits) << len) | ACC_W'(code_table[it.symbol]);
			total = int'(held_count) + int'(len);
			while (total >= 8) begin
				ob.out_byte = BYTE_W'(acc >> (total - 8));
				ob.last_of_run = 1'b0;
				ob.is_tail = 1'b0;
				run.push_back(ob);
				total -= 8;
			end
			if (run.size() != 0)
				run[run.size()-1].last_of_run = 1'b1;
			foreach (run[i])
				expected_bytes.push_back(run[i]);
			held_bits = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
			held_count = PCNT_W'(total);
		end
		CMD_FLUSH: begin
			if (held_count != 0) begin
				ob.out_byte = BYTE_W'({1'b0, held_bits} << (8 - held_count));
				ob.last_of_run = 1'b1;
				ob.is_tail = 1'b1;
				expected_bytes.push_back(ob);
			end
			held_bits = '0;
			held_count = '0;
		end
		default: ;
		endcase
	endfunction

	task automatic queue_cmd(logic [1:0] c, logic [SYM_W-1:0] s, logic [CODE_W-1:0] b,
			logic [LEN_W-1:0] l);
		in_item_t it;
		it.cmd = c;
		it.symbol = s;
		it.code_bits = b;
		it.code_len = l;
		cmd_queue.push_back(it);
	endtask

	// mostly short codes, some long, some overlong, the odd empty one
	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r < 3)
			return LEN_W'($urandom_range(33, 63));
		else if (r < 6)
			return LEN_W'($urandom_range(13, 32));
		else
			return LEN_W'($urandom_range(1, 12));
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || !src_stall) begin
			if (src_gap > 0) begin
				src_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (cmd_queue.size() != 0) begin
				src_data <= cmd_queue.pop_front();
				src_valid <= 1'b1;
				if (bursts_allowed() && $urandom_range(0, 5) == 0)
					src_gap <= $urandom_range(1, 10);
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// result-side stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (bursts_allowed() && $urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor: check the byte leaving first, then predict from the item entering
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				n_bytes++;
				if (res_data.is_tail)
					n_tails++;
				if (expected_bytes.size() == 0) begin
					$error("unexpected packed byte: out_byte %h", res_data.out_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (res_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, res_data.out_byte);
						mismatches++;
					end
					if (res_data.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b",
							want.last_of_run, res_data.last_of_run);
						mismatches++;
					end
					if (res_data.is_tail !== want.is_tail) begin
						$error("is_tail: expected %b, got %b", want.is_tail, res_data.is_tail);
						mismatches++;
					end
				end
			end
			if (src_valid && !src_stall) begin
				case (src_data.cmd)
				CMD_LOAD: n_loads++;
				CMD_ENCODE: n_encodes++;
				CMD_FLUSH: n_flushes++;
				default: ;
				endcase
				pack_item(src_data);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// stimulus and end of run
	initial begin : stimulus
		bit is_loaded[256];
		logic [SYM_W-1:0] loaded_syms[$];
		int issued;
		int pick;
		logic [SYM_W-1:0] sym;

		// directed: zero-length code, saturation, up to four bytes per item, tails
		queue_cmd(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		queue_cmd(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		queue_cmd(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
		queue_cmd(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
		queue_cmd(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		queue_cmd(CMD_LOAD, 8'hAA, 32'h0000_0005, 6'd3);
		queue_cmd(CMD_LOAD, 8'h01, 32'h0000_0001, 6'd1);
		queue_cmd(CMD_ENCODE, 8'hAA, 32'h0, 6'd0);
		queue_cmd(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
		queue_cmd(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
		repeat (4) queue_cmd(CMD_ENCODE, 8'h01, 32'h0, 6'd0);
		queue_cmd(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
		queue_cmd(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		queue_cmd(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		queue_cmd(CMD_LOAD, 8'h80, 32'h1234_5678, 6'd33);
		queue_cmd(CMD_ENCODE, 8'h80, 32'h0, 6'd0);
		queue_cmd(CMD_LOAD, 8'h7E, 32'hDEAD_BEEF, 6'd12);
		queue_cmd(CMD_ENCODE, 8'h7E, 32'h0, 6'd0);
		queue_cmd(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
		queue_cmd(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		foreach (is_loaded[i])
			is_loaded[i] = 1'b0;
		foreach (cmd_queue[i])
			if (cmd_queue[i].cmd == CMD_LOAD && !is_loaded[cmd_queue[i].symbol]) begin
				is_loaded[cmd_queue[i].symbol] = 1'b1;
				loaded_syms.push_back(cmd_queue[i].symbol);
			end

		// random: a table set-up, then mostly encodes of loaded symbols
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			pick = (issued < 16) ? 80 : $urandom_range(0, 99);
			if (pick < 62) begin
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				queue_cmd(CMD_ENCODE, sym, $urandom(), 6'($urandom()));
				issued++;
			end else if (pick < 72) begin
				queue_cmd(CMD_FLUSH, 8'($urandom()), $urandom(), 6'($urandom()));
				issued++;
			end else if (pick < 95) begin
				sym = 8'($urandom());
				queue_cmd(CMD_LOAD, sym, $urandom(), pick_len());
				if (!is_loaded[sym]) begin
					is_loaded[sym] = 1'b1;
					loaded_syms.push_back(sym);
				end
				issued++;
			end else begin
				queue_cmd(CMD_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()));
			end
		end
		queue_cmd(CMD_FLUSH, 8'h00, 32'h0, 6'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || src_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d loads, %0d encodes and %0d flushes over %0d cycles,",
			n_loads, n_encodes, n_flushes, cycle_count);
		$display("with %0d packed bytes checked, %0d of them padded tail bytes.",
			n_bytes, n_tails);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
